// File: rtl/active_expired_priority_run_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Run queue assertion macros
// Shared concurrent assertion wrappers for the run queue RTL.
// ----------------------------------------------------------------------------
`ifndef ACTIVE_EXPIRED_PRIORITY_RUN_QUEUE_UNIT_MACROS_SVH
`define ACTIVE_EXPIRED_PRIORITY_RUN_QUEUE_UNIT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define EAPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every rising edge, including reset.
`define EAPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: rtl/eapq_pkg.sv
// ----------------------------------------------------------------------------
// Run queue package
// Sizes, payload types and operation codes shared by the run queue RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package eapq_pkg;

    localparam int MAX_LEVELS  = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;

    localparam int TASK_W  = 8;
    localparam int PRIO_W  = 3;
    localparam int CFG_W   = 4;
    localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int LCNT_W  = ($clog2(MAX_LEVELS + 1) > CFG_W) ? $clog2(MAX_LEVELS + 1) : CFG_W;
    localparam int ADDR_W  = 1 + LVL_W + PTR_W;
    localparam int RAM_DEPTH = 2 ** ADDR_W;
    localparam logic [CFG_W-1:0] LEVELS_RESET = CFG_W'(4);

    typedef enum logic [1:0] {
        ACT_ENQ_ACTIVE  = 2'd0,
        ACT_ENQ_EXPIRED = 2'd1,
        ACT_DEQUEUE     = 2'd2,
        ACT_PEEK        = 2'd3
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [TASK_W-1:0]   task_id;
        logic [PRIO_W-1:0]   priority_req;
    } t_item;

    typedef struct packed {
        logic                valid_res;
        logic [TASK_W-1:0]   out_task_id;
        logic [PRIO_W-1:0]   out_priority;
        logic                swapped;
        logic                error;
    } t_result;

    typedef struct packed {
        logic                swap;
        logic                found;
        logic [LVL_W-1:0]    level;
    } t_sel;

endpackage

`default_nettype wire

// File: rtl/eapq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module eapq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/eapq_sel.sv
// ----------------------------------------------------------------------------
// Run queue level selector
// Decides the bank swap and picks the highest non-empty level in use.
// ----------------------------------------------------------------------------
`default_nettype none

module eapq_sel (
    input  wire logic [eapq_pkg::MAX_LEVELS-1:0] i_ne_act,
    input  wire logic [eapq_pkg::MAX_LEVELS-1:0] i_ne_exp,
    input  wire logic [eapq_pkg::LCNT_W-1:0]     i_levels,
    output eapq_pkg::t_sel                       o_sel
);

    logic [eapq_pkg::MAX_LEVELS-1:0] mask;
    logic [eapq_pkg::MAX_LEVELS-1:0] pick;
    logic                            any_act;

    always_comb begin
        for (int l = 0; l < eapq_pkg::MAX_LEVELS; l++) begin
            mask[l] = (eapq_pkg::LCNT_W'(l) < i_levels);
        end
        any_act = |(i_ne_act & mask);
        pick    = (any_act ? i_ne_act : i_ne_exp) & mask;

        o_sel.swap  = !any_act;
        o_sel.found = 1'b0;
        o_sel.level = '0;
        for (int l = 0; l < eapq_pkg::MAX_LEVELS; l++) begin
            if (pick[l]) begin
                o_sel.found = 1'b1;
                o_sel.level = eapq_pkg::LVL_W'(l);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/active_expired_priority_run_queue_unit.sv
// ----------------------------------------------------------------------------
// Active/expired priority run queue
// Two banks of per-level task FIFOs with enqueue, dequeue, peek and bank swap.
// ----------------------------------------------------------------------------
// An item is taken on every cycle in which start is high and busy is low;
// busy is high only while reset is applied and in the cycle after it. Each
// item produces exactly one result beat, shown on o_result with o_done high
// for a single cycle, and one item per cycle is sustained. Between the taking
// of an item and its result beat lie the input register stage, where level
// selection and the head and count update happen, and the registered
// read of the task store RAM. The receiver cannot stall: a result beat that
// is not captured in its cycle is gone. The task store needs no clearing
// pass after reset because only entries inside a FIFO's count are read.
`default_nettype none
`include "active_expired_priority_run_queue_unit_macros.svh"

module active_expired_priority_run_queue_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire eapq_pkg::t_item              i_item,
    input  wire logic                         i_cfg_we,
    input  wire logic [eapq_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                              o_done,
    output eapq_pkg::t_result                 o_result
);

    logic                              r_busy;
    logic                              r_v1;
    logic                              r_v2;
    logic                              r_bank_sel;
    logic [eapq_pkg::CFG_W-1:0]        r_levels;
    logic [eapq_pkg::PTR_W-1:0]        r_head  [2][eapq_pkg::MAX_LEVELS];
    logic [eapq_pkg::CNT_W-1:0]        r_count [2][eapq_pkg::MAX_LEVELS];
    eapq_pkg::t_item                   r_item;
    eapq_pkg::t_result                 r_res;

    logic [eapq_pkg::LCNT_W-1:0]       eff_levels;
    logic [eapq_pkg::MAX_LEVELS-1:0]   ne_act;
    logic [eapq_pkg::MAX_LEVELS-1:0]   ne_exp;
    eapq_pkg::t_sel                    sel;
    logic                              is_enq;
    logic                              is_deq;
    logic                              enq_bank;
    logic                              act_bank;
    logic                              sel_bank;
    logic [eapq_pkg::LVL_W-1:0]        sel_lvl;
    logic [eapq_pkg::PTR_W-1:0]        cur_head;
    logic [eapq_pkg::CNT_W-1:0]        cur_cnt;
    logic                              bad_level;
    logic                              enq_ok;
    logic [eapq_pkg::PTR_W:0]          slot_sum;
    logic [eapq_pkg::PTR_W-1:0]        slot;
    logic [eapq_pkg::PTR_W-1:0]        n_head;
    logic                              ram_we;
    logic                              ram_re;
    logic [eapq_pkg::ADDR_W-1:0]       ram_waddr;
    logic [eapq_pkg::ADDR_W-1:0]       ram_raddr;
    logic [eapq_pkg::ID_BITS-1:0]      ram_wdata;
    logic [eapq_pkg::ID_BITS-1:0]      ram_rdata;
    eapq_pkg::t_result                 n_res;

    always_comb begin
        eff_levels = (eapq_pkg::LCNT_W'(r_levels) > eapq_pkg::LCNT_W'(eapq_pkg::MAX_LEVELS))
                   ? eapq_pkg::LCNT_W'(eapq_pkg::MAX_LEVELS)
                   : eapq_pkg::LCNT_W'(r_levels);
        for (int l = 0; l < eapq_pkg::MAX_LEVELS; l++) begin
            ne_act[l] = (r_count[r_bank_sel][l] != '0);
            ne_exp[l] = (r_count[!r_bank_sel][l] != '0);
        end
    end

    eapq_sel u_sel (
        .i_ne_act (ne_act),
        .i_ne_exp (ne_exp),
        .i_levels (eff_levels),
        .o_sel    (sel)
    );

    always_comb begin
        is_enq    = (r_item.action == eapq_pkg::ACT_ENQ_ACTIVE) ||
                    (r_item.action == eapq_pkg::ACT_ENQ_EXPIRED);
        is_deq    = (r_item.action == eapq_pkg::ACT_DEQUEUE);
        enq_bank  = r_bank_sel ^ (r_item.action == eapq_pkg::ACT_ENQ_EXPIRED);
        act_bank  = r_bank_sel ^ sel.swap;
        sel_bank  = is_enq ? enq_bank : act_bank;
        sel_lvl   = is_enq ? eapq_pkg::LVL_W'(r_item.priority_req) : sel.level;
        cur_head  = r_head[sel_bank][sel_lvl];
        cur_cnt   = r_count[sel_bank][sel_lvl];
        bad_level = (eapq_pkg::LCNT_W'(r_item.priority_req) >= eff_levels);
        enq_ok    = is_enq && !bad_level &&
                    (cur_cnt != eapq_pkg::CNT_W'(eapq_pkg::QUEUE_DEPTH));

        slot_sum = {1'b0, cur_head} + (eapq_pkg::PTR_W + 1)'(cur_cnt);
        if (slot_sum >= (eapq_pkg::PTR_W + 1)'(eapq_pkg::QUEUE_DEPTH)) begin
            slot = eapq_pkg::PTR_W'(slot_sum - (eapq_pkg::PTR_W + 1)'(eapq_pkg::QUEUE_DEPTH));
        end else begin
            slot = eapq_pkg::PTR_W'(slot_sum);
        end
        n_head = (cur_head == eapq_pkg::PTR_W'(eapq_pkg::QUEUE_DEPTH - 1))
               ? '0 : cur_head + eapq_pkg::PTR_W'(1);

        ram_we    = r_v1 && enq_ok;
        ram_re    = r_v1 && !is_enq && sel.found;
        ram_waddr = {sel_bank, sel_lvl, slot};
        ram_raddr = {sel_bank, sel_lvl, cur_head};
        ram_wdata = eapq_pkg::ID_BITS'(r_item.task_id);

        n_res.valid_res    = !is_enq && sel.found;
        n_res.out_task_id  = '0;
        n_res.out_priority = (!is_enq && sel.found) ? eapq_pkg::PRIO_W'(sel.level) : '0;
        n_res.swapped      = !is_enq && sel.swap;
        n_res.error        = is_enq && !enq_ok;
    end

    eapq_ram #(
        .WIDTH (eapq_pkg::ID_BITS),
        .DEPTH (eapq_pkg::RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_bank_sel <= 1'b0;
            r_levels   <= eapq_pkg::LEVELS_RESET;
            for (int b = 0; b < 2; b++) begin
                for (int l = 0; l < eapq_pkg::MAX_LEVELS; l++) begin
                    r_head[b][l]  <= '0;
                    r_count[b][l] <= '0;
                end
            end
        end else begin
            r_busy <= 1'b0;
            r_v1   <= start && !busy;
            r_v2   <= r_v1;
            if (i_cfg_we) begin
                r_levels <= i_cfg_wdata;
            end
            if (r_v1) begin
                if (!is_enq && sel.swap) begin
                    r_bank_sel <= !r_bank_sel;
                end
                if (enq_ok) begin
                    r_count[sel_bank][sel_lvl] <= cur_cnt + eapq_pkg::CNT_W'(1);
                end else if (is_deq && sel.found) begin
                    r_head[sel_bank][sel_lvl]  <= n_head;
                    r_count[sel_bank][sel_lvl] <= cur_cnt - eapq_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_item <= i_item;
        end
        if (r_v1) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        busy     = r_busy;
        o_done   = r_v2;
        o_result = r_res;
        o_result.out_task_id = r_res.valid_res ? eapq_pkg::TASK_W'(ram_rdata) : '0;
    end

    `EAPQ_ASSERT(a_result_latency, (start && !busy) |-> ##2 o_done,
        "accepted item did not produce a result beat two cycles later")
    `EAPQ_ASSERT(a_swap_flips_bank, (r_v1 && !is_enq && sel.swap) |=>
        (r_bank_sel != $past(r_bank_sel)), "bank select did not flip on a swap")
    `EAPQ_ASSERT(a_no_result_id_zero, (o_done && !o_result.valid_res) |->
        (o_result.out_task_id == '0), "empty result beat carries a task id")
    `EAPQ_ASSERT(a_enq_fields_quiet, (o_done && o_result.error) |->
        (!o_result.valid_res && !o_result.swapped), "dropped enqueue reports a task or swap")
    `EAPQ_ASSERT_ALWAYS(a_no_ram_conflict, !((ram_we === 1'b1) && (ram_re === 1'b1)),
        "task store written and read by one item")

endmodule

`default_nettype wire

// File: sim/active_expired_priority_run_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active/expired priority run queue testbench
// Drives enqueue, dequeue and peek commands under several level counts, runs
// its own two-bank queue predictor on every accepted command, and checks each
// result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module active_expired_priority_run_queue_unit_tb;

    localparam int RESET_CYCLES  = 9;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 90;
    localparam int EXP_DEPTH     = 16;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    eapq_pkg::t_item            i_item;
    logic                       i_cfg_we;
    logic [eapq_pkg::CFG_W-1:0] i_cfg_wdata;
    logic                       o_done;
    eapq_pkg::t_result          o_result;

    logic [eapq_pkg::TASK_W-1:0] model_store [2][eapq_pkg::MAX_LEVELS][eapq_pkg::QUEUE_DEPTH];
    int                          model_head  [2][eapq_pkg::MAX_LEVELS];
    int                          model_count [2][eapq_pkg::MAX_LEVELS];
    logic                        model_bank;
    logic [eapq_pkg::CFG_W-1:0]  model_levels;

    eapq_pkg::t_result          expected_results [EXP_DEPTH];
    int                         exp_wr = 0;
    int                         exp_rd = 0;
    int                         mismatch_count = 0;
    int                         stall_cycles = 0;

    active_expired_priority_run_queue_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic eapq_pkg::t_item make_item(eapq_pkg::t_action act, int id, int prio);
        eapq_pkg::t_item it;
        it.action       = act;
        it.task_id      = eapq_pkg::TASK_W'(id);
        it.priority_req = eapq_pkg::PRIO_W'(prio);
        return it;
    endfunction

    function automatic int effective_levels(int value);
        return (value > eapq_pkg::MAX_LEVELS) ? eapq_pkg::MAX_LEVELS : value;
    endfunction

    function automatic int pending_count();
        return exp_wr - exp_rd;
    endfunction

    function automatic eapq_pkg::t_result predict_run_queue(eapq_pkg::t_item it);
        eapq_pkg::t_result r;
        int      eff;
        int      lvl;
        int      bank;
        int      slot;
        int      l;
        logic    any_ready;
        r = '0;
        eff = effective_levels(int'(model_levels));
        lvl = int'(it.priority_req);
        case (it.action)
            eapq_pkg::ACT_ENQ_ACTIVE, eapq_pkg::ACT_ENQ_EXPIRED: begin
                bank = (it.action == eapq_pkg::ACT_ENQ_EXPIRED) ? int'(!model_bank)
                                                                : int'(model_bank);
                if (lvl >= eff || model_count[bank][lvl] >= eapq_pkg::QUEUE_DEPTH) begin
                    r.error = 1'b1;
                end else begin
                    slot = (model_head[bank][lvl] + model_count[bank][lvl])
                           % eapq_pkg::QUEUE_DEPTH;
                    model_store[bank][lvl][slot] = it.task_id;
                    model_count[bank][lvl] = model_count[bank][lvl] + 1;
                end
            end
            default: begin
                any_ready = 1'b0;
                for (l = 0; l < eff; l++) begin
                    if (model_count[model_bank][l] != 0) any_ready = 1'b1;
                end
                if (!any_ready) begin
                    model_bank = ~model_bank;
                    r.swapped  = 1'b1;
                end
                bank = int'(model_bank);
                for (l = eff - 1; l >= 0 && !r.valid_res; l--) begin
                    if (model_count[bank][l] != 0) begin
                        r.valid_res    = 1'b1;
                        r.out_task_id  = model_store[bank][l][model_head[bank][l]];
                        r.out_priority = eapq_pkg::PRIO_W'(l);
                        if (it.action == eapq_pkg::ACT_DEQUEUE) begin
                            model_head[bank][l]  = (model_head[bank][l] + 1)
                                                   % eapq_pkg::QUEUE_DEPTH;
                            model_count[bank][l] = model_count[bank][l] - 1;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic issue_command(eapq_pkg::t_item it);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_results[exp_wr % EXP_DEPTH] = predict_run_queue(it);
        exp_wr++;
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            @(negedge i_clk);
            start  <= 1'b0;
            i_item <= make_item(eapq_pkg::t_action'($urandom_range(0, 3)),
                                $urandom_range(0, 255), $urandom_range(0, 7));
            repeat (n - 1) begin
                @(negedge i_clk);
                i_item <= make_item(eapq_pkg::t_action'($urandom_range(0, 3)),
                                    $urandom_range(0, 255), $urandom_range(0, 7));
            end
        end
    endtask

    task automatic pause_randomly();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) idle_cycles(0);
        else if (pick < 92) idle_cycles($urandom_range(1, 3));
        else idle_cycles($urandom_range(6, 30));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_count() != 0) @(posedge i_clk);
    endtask

    task automatic write_level_count(int value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= eapq_pkg::CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_levels = eapq_pkg::CFG_W'(value);
    endtask

    task automatic test_empty_queue();
        issue_command(make_item(eapq_pkg::ACT_PEEK, 0, 0));
        issue_command(make_item(eapq_pkg::ACT_DEQUEUE, 255, 7));
    endtask

    task automatic test_enqueue_limits();
        issue_command(make_item(eapq_pkg::ACT_ENQ_ACTIVE, 0, 0));
        issue_command(make_item(eapq_pkg::ACT_ENQ_ACTIVE, 255, 3));
        issue_command(make_item(eapq_pkg::ACT_ENQ_ACTIVE, 17, 4));
        issue_command(make_item(eapq_pkg::ACT_ENQ_ACTIVE, 18, 7));
        issue_command(make_item(eapq_pkg::ACT_ENQ_EXPIRED, 165, 2));
        issue_command(make_item(eapq_pkg::ACT_ENQ_EXPIRED, 90, 4));
    endtask

    task automatic test_service_order();
        issue_command(make_item(eapq_pkg::ACT_PEEK, 0, 0));
        issue_command(make_item(eapq_pkg::ACT_DEQUEUE, 0, 0));
        issue_command(make_item(eapq_pkg::ACT_DEQUEUE, 0, 0));
        issue_command(make_item(eapq_pkg::ACT_DEQUEUE, 0, 0));
        issue_command(make_item(eapq_pkg::ACT_DEQUEUE, 0, 0));
    endtask

    task automatic test_level_count();
        write_level_count(15);
        issue_command(make_item(eapq_pkg::ACT_ENQ_ACTIVE, 90, 7));
        issue_command(make_item(eapq_pkg::ACT_PEEK, 0, 0));
        write_level_count(0);
        issue_command(make_item(eapq_pkg::ACT_ENQ_ACTIVE, 1, 0));
        issue_command(make_item(eapq_pkg::ACT_PEEK, 0, 0));
        issue_command(make_item(eapq_pkg::ACT_PEEK, 0, 0));
        write_level_count(8);
        issue_command(make_item(eapq_pkg::ACT_DEQUEUE, 0, 0));
        write_level_count(9);
        issue_command(make_item(eapq_pkg::ACT_ENQ_ACTIVE, 200, 7));
        issue_command(make_item(eapq_pkg::ACT_DEQUEUE, 0, 0));
    endtask

    task automatic test_random_traffic();
        int                levels_plan [10] = '{8, 1, 15, 0, 3, 9, 6, 2, 8, 4};
        int                eff;
        int                issued;
        int                pick;
        int                prio;
        bit                steady;
        eapq_pkg::t_action act;
        foreach (levels_plan[p]) begin
            write_level_count(levels_plan[p]);
            eff    = effective_levels(levels_plan[p]);
            steady = ($urandom_range(0, 3) == 0);
            issued = 0;
            while (issued < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    act  = ($urandom_range(0, 1) != 0) ? eapq_pkg::ACT_ENQ_ACTIVE
                                                       : eapq_pkg::ACT_ENQ_EXPIRED;
                    prio = (eff > 0) ? $urandom_range(0, eff - 1) : $urandom_range(0, 7);
                    repeat ($urandom_range(14, 20)) begin
                        issue_command(make_item(act, $urandom_range(0, 255), prio));
                        if (!steady) pause_randomly();
                        issued++;
                    end
                end else begin
                    if (pick < 36) act = eapq_pkg::ACT_ENQ_ACTIVE;
                    else if (pick < 56) act = eapq_pkg::ACT_ENQ_EXPIRED;
                    else if (pick < 84) act = eapq_pkg::ACT_DEQUEUE;
                    else act = eapq_pkg::ACT_PEEK;
                    if (eff > 0 && $urandom_range(0, 9) < 8) prio = $urandom_range(0, eff - 1);
                    else prio = $urandom_range(0, 7);
                    issue_command(make_item(act, $urandom_range(0, 255), prio));
                    if (!steady) pause_randomly();
                    issued++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        eapq_pkg::t_result want;
        if (i_rst_n) begin
            if ((start && !busy) || o_done) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (o_done) begin
                if (pending_count() == 0) begin
                    report_mismatch("result beat with nothing pending", 1, 0);
                end else begin
                    want = expected_results[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (o_result.valid_res !== want.valid_res)
                        report_mismatch("valid_res", o_result.valid_res, want.valid_res);
                    if (o_result.out_task_id !== want.out_task_id)
                        report_mismatch("out_task_id", o_result.out_task_id, want.out_task_id);
                    if (o_result.out_priority !== want.out_priority)
                        report_mismatch("out_priority", o_result.out_priority,
                                        want.out_priority);
                    if (o_result.swapped !== want.swapped)
                        report_mismatch("swapped", o_result.swapped, want.swapped);
                    if (o_result.error !== want.error)
                        report_mismatch("error", o_result.error, want.error);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_item         = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        model_bank     = 1'b0;
        model_levels   = eapq_pkg::LEVELS_RESET;
        foreach (model_store[b, l, s]) model_store[b][l][s] = '0;
        foreach (model_count[b, l]) begin
            model_head[b][l]  = 0;
            model_count[b][l] = 0;
        end
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_enqueue_limits();
        test_service_order();
        test_level_count();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
